// ----- design/rcsd_pkg.sv -----
// ----------------------------------------------------------------------------
// rcsd_pkg - shared constants and types for the serial frame servo decoder
// Frame geometry, channel count, scaling constants and the stage-one record.
// ----------------------------------------------------------------------------
package rcsd_pkg;

    localparam int FRAME_BYTES   = 16;
    localparam int CHANNEL_COUNT = 12;

    // byte counter must be able to hold FRAME_BYTES itself (end of frame)
    localparam int POS_W    = $clog2(FRAME_BYTES + 1);
    localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    localparam int HEADER_BYTES = 2;
    localparam int SERVO_LIMIT  = 5000;
    localparam int CENTRE_10    = 512;
    localparam int CENTRE_11    = 1024;

    // x / 5 == (x * 52429) >> 18 for every x below 2^18
    localparam int RECIP_5     = 52429;
    localparam int RECIP_SHIFT = 18;

    localparam logic MODE_10BIT = 1'b0;
    localparam logic MODE_11BIT = 1'b1;
    localparam logic MODE_RESET = MODE_11BIT;

    localparam int CHAN_W  = 4;
    localparam int POSN_W  = 11;
    localparam int SERVO_W = 14;
    localparam int MAG_W   = 16;

    // decoded word waiting for the scaling stage
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [POSN_W-1:0] raw_position;
        logic [MAG_W-1:0]  mag;   // |centred * 29 (or 58)|
        logic              neg;
    } t_s1;

endpackage

// ----- design/rcsd_byte_if.sv -----
// ----------------------------------------------------------------------------
// rcsd_byte_if - frame byte channel
// Valid/ready channel carrying one receiver byte and its frame start mark.
// ----------------------------------------------------------------------------
interface rcsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_start;

    modport source (output valid, output frame_byte, output frame_start, input ready);
    modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

// ----- design/rcsd_servo_if.sv -----
// ----------------------------------------------------------------------------
// rcsd_servo_if - decoded servo channel
// Valid/ready channel carrying one decoded channel word.
// ----------------------------------------------------------------------------
interface rcsd_servo_if;
    logic               valid;
    logic               ready;
    logic [3:0]         channel;
    logic [10:0]        raw_position;
    logic signed [13:0] servo_value;
    logic               in_range;

    modport source (output valid, output channel, output raw_position,
                    output servo_value, output in_range, input ready);
    modport sink   (input valid, input channel, input raw_position,
                    input servo_value, input in_range, output ready);
endinterface

// ----- design/rc_serial_frame_servo_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// rc_serial_frame_servo_decoder_unit - serial RC frame to servo values
// Decodes channel words of a satellite receiver frame into servo values.
// ----------------------------------------------------------------------------
// Use:
//   i_byte  : one frame byte per word, frame_start marks byte 0 of a frame.
//             Bytes 0 and 1 are header; later pairs are high/low of a word.
//             Bytes past FRAME_BYTES are dropped until the next frame start.
//   o_servo : one word per low byte whose channel is below CHANNEL_COUNT:
//             channel, raw position, servo value and in_range. When the
//             scaled value falls outside +-5000 the last good value of that
//             channel is sent with in_range low.
//   i_cfg_we/i_cfg_wdata : resolution mode, 0 = 10-bit, 1 = 11-bit (reset).
//             Write only while the block is empty.
// Timing: one word accepted per cycle while the output is not stalled; each
//   result passes the word assembler register, then the output register.
// Reset (synchronous, active low): byte counter, pending high byte, both
//   pipeline valids and all per-channel held values go to zero; mode to 1.
// Back-pressure: a stalled output word holds; the assembler register still
//   takes one more word behind it, then i_byte.ready drops.
// ----------------------------------------------------------------------------
module rc_serial_frame_servo_decoder_unit
    import rcsd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    rcsd_byte_if.sink     i_byte,
    rcsd_servo_if.source  o_servo,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata
);

    logic r_mode;

    logic s1_vld;
    t_s1  s1;
    logic out_free;
    logic adv;

    // held value per channel, cleared by reset
    logic signed [SERVO_W-1:0] r_last [CHANNEL_COUNT];

    logic [31:0]               recip_prod;
    logic [SERVO_W-1:0]        quot;
    logic                      ok;
    logic signed [SERVO_W-1:0] scaled;
    logic signed [SERVO_W-1:0] held;
    logic [CH_IDX_W-1:0]       idx;

    logic                      r_out_vld;
    logic [CHAN_W-1:0]         r_chan;
    logic [POSN_W-1:0]         r_rawp;
    logic signed [SERVO_W-1:0] r_servo;
    logic                      r_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    rcsd_word_asm u_asm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_mode   (r_mode),
        .i_adv    (adv),
        .o_s1_vld (s1_vld),
        .o_s1     (s1)
    );

    assign out_free = !r_out_vld || o_servo.ready;
    assign adv      = s1_vld && out_free;

    // divide magnitude by 5 with a reciprocal multiply; truncates toward zero
    assign recip_prod = {{(32 - MAG_W){1'b0}}, s1.mag} * 32'(RECIP_5);
    assign quot       = recip_prod[RECIP_SHIFT +: SERVO_W];
    assign ok         = quot <= SERVO_W'(SERVO_LIMIT);
    assign scaled     = s1.neg ? -$signed(quot) : $signed(quot);
    assign idx        = s1.chan[CH_IDX_W-1:0];
    assign held       = r_last[idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            for (int k = 0; k < CHANNEL_COUNT; k++) begin
                r_last[k] <= '0;
            end
        end else begin
            if (adv) begin
                r_out_vld <= 1'b1;
                if (ok) begin
                    r_last[idx] <= scaled;
                end
            end else if (o_servo.ready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (adv) begin
            r_chan  <= s1.chan;
            r_rawp  <= s1.raw_position;
            r_servo <= ok ? scaled : held;
            r_ok    <= ok;
        end
    end

    assign o_servo.valid        = r_out_vld;
    assign o_servo.channel      = r_chan;
    assign o_servo.raw_position = r_rawp;
    assign o_servo.servo_value  = r_servo;
    assign o_servo.in_range     = r_ok;

endmodule

// ----- design/rcsd_word_asm.sv -----
// ----------------------------------------------------------------------------
// rcsd_word_asm - frame byte counter and word assembler
// Tracks position in the frame, pairs high/low bytes, decodes channel and
// position, centres and scales by 29 or 58, registers the result.
// ----------------------------------------------------------------------------
module rcsd_word_asm
    import rcsd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    rcsd_byte_if.sink    i_byte,
    input  logic         i_mode,
    input  logic         i_adv,
    output logic         o_s1_vld,
    output t_s1          o_s1
);

    logic [POS_W-1:0] r_byte_pos, n_byte_pos;
    logic [7:0]       r_pending, n_pending;
    logic             r_vld, n_vld;
    t_s1              r_s1, n_s1;

    logic                    accept;
    logic [POS_W-1:0]        pos;
    logic                    in_frame;
    logic                    is_low;
    logic [CHAN_W-1:0]       chan;
    logic [POSN_W-1:0]       rawp;
    logic signed [11:0]      centred;
    logic signed [16:0]      c_ext;
    logic signed [16:0]      p29;
    logic signed [16:0]      prod;
    logic [16:0]             prod_abs;
    logic                    chan_ok;

    assign i_byte.ready = !r_vld || i_adv;
    assign accept       = i_byte.valid && i_byte.ready;

    assign pos      = i_byte.frame_start ? '0 : r_byte_pos;
    assign in_frame = pos < POS_W'(FRAME_BYTES);
    assign is_low   = in_frame && pos[0] && (pos > POS_W'(HEADER_BYTES));

    always_comb begin
        if (i_mode == MODE_11BIT) begin
            chan    = r_pending[6:3];
            rawp    = {r_pending[2:0], i_byte.frame_byte};
            centred = $signed({1'b0, rawp}) - 12'sd1024;
        end else begin
            chan    = r_pending[5:2];
            rawp    = {1'b0, r_pending[1:0], i_byte.frame_byte};
            centred = $signed({1'b0, rawp}) - 12'sd512;
        end
    end

    // x * 29 = 32x - 2x - x; 10-bit mode doubles it
    assign c_ext    = {{5{centred[11]}}, centred};
    assign p29      = (c_ext <<< 5) - (c_ext <<< 1) - c_ext;
    assign prod     = (i_mode == MODE_11BIT) ? p29 : (p29 <<< 1);
    assign prod_abs = prod[16] ? 17'(-prod) : 17'(prod);
    assign chan_ok  = {1'b0, chan} < (CHAN_W + 1)'(CHANNEL_COUNT);

    always_comb begin
        n_byte_pos = r_byte_pos;
        n_pending  = r_pending;
        n_vld      = r_vld;
        n_s1       = r_s1;
        if (accept) begin
            if (in_frame) begin
                n_byte_pos = pos + POS_W'(1);
            end else begin
                n_byte_pos = pos;
            end
            if (in_frame && !pos[0] && (pos >= POS_W'(HEADER_BYTES))) begin
                n_pending = i_byte.frame_byte;
            end
            n_vld             = is_low && chan_ok;
            n_s1.chan         = chan;
            n_s1.raw_position = rawp;
            n_s1.mag          = prod_abs[MAG_W-1:0];
            n_s1.neg          = prod[16];
        end else if (i_adv) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos <= '0;
            r_pending  <= '0;
            r_vld      <= 1'b0;
        end else begin
            r_byte_pos <= n_byte_pos;
            r_pending  <= n_pending;
            r_vld      <= n_vld;
        end
        r_s1 <= n_s1;
    end

    assign o_s1_vld = r_vld;
    assign o_s1     = r_s1;

endmodule

// ----- design/rcsd_checker.sv -----
// ----------------------------------------------------------------------------
// rcsd_checker - port-level checks for the servo decoder
// Watches the output channel; bound to the top level.
// ----------------------------------------------------------------------------
module rcsd_checker
    import rcsd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [CHAN_W-1:0]         i_channel,
    input  logic [POSN_W-1:0]         i_raw_position,
    input  logic signed [SERVO_W-1:0] i_servo_value,
    input  logic                      i_in_range
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_channel)
            && $stable(i_raw_position) && $stable(i_servo_value)
            && $stable(i_in_range))
        else $error("output word changed while stalled");

    // held values only ever come from plausible scaled values
    a_servo_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_servo_value <= SERVO_W'(SERVO_LIMIT))
            && (i_servo_value >= -SERVO_W'(SERVO_LIMIT)))
        else $error("servo value outside limit");

    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ({1'b0, i_channel} < (CHAN_W + 1)'(CHANNEL_COUNT)))
        else $error("word for a channel beyond the count");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind rc_serial_frame_servo_decoder_unit rcsd_checker u_rcsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_servo.valid),
    .i_out_ready    (o_servo.ready),
    .i_channel      (o_servo.channel),
    .i_raw_position (o_servo.raw_position),
    .i_servo_value  (o_servo.servo_value),
    .i_in_range     (o_servo.in_range)
);
